// File: rtl/micd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// micd_pkg
// Opcode codes, field positions and class tables for the instruction
// class decoder.
// ----------------------------------------------------------------------------
package micd_pkg;

  localparam int OPC_LSB = 26;
  localparam int SEL_BIT = 25;
  localparam int RS_LSB  = 21;
  localparam int RT_LSB  = 16;

  localparam int CLASS_W = 8;

  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_REGIMM  = 6'h01;
  localparam logic [5:0] OPC_COP0    = 6'h10;
  localparam logic [5:0] OPC_COP1    = 6'h11;
  localparam logic [5:0] OPC_COP2    = 6'h12;

  localparam logic [5:0] FN_TLBR  = 6'h01;
  localparam logic [5:0] FN_TLBWI = 6'h02;
  localparam logic [5:0] FN_TLBWR = 6'h06;
  localparam logic [5:0] FN_TLBP  = 6'h08;
  localparam logic [5:0] FN_ERET  = 6'h18;

  localparam logic [7:0] CLS_INVALID = 8'd0;
  localparam logic [7:0] CLS_TLBR    = 8'd74;
  localparam logic [7:0] CLS_TLBWI   = 8'd75;
  localparam logic [7:0] CLS_TLBWR   = 8'd76;
  localparam logic [7:0] CLS_TLBP    = 8'd77;
  localparam logic [7:0] CLS_ERET    = 8'd78;
  localparam logic [7:0] CLS_MAX     = 8'd180;

  localparam logic [7:0] COP0_RS_BASE = 8'd66;
  localparam logic [7:0] COP1_RS_BASE = 8'd78;
  localparam logic [7:0] COP2_RS_BASE = 8'd121;
  localparam logic [7:0] COP1_FN_BASE = 8'd85;

  localparam logic [7:0] SPECIAL_CLS [64] = '{
     1,  0,  2,  3,  4,  0,  5,  6,
     7,  8,  0,  0,  9, 10,  0, 11,
    12, 13, 14, 15, 16,  0, 17, 18,
    19, 20, 21, 22, 23, 24, 25, 26,
    27, 28, 29, 30, 31, 32, 33, 34,
     0,  0, 35, 36, 37, 38, 39, 40,
    41, 42, 43, 44, 45,  0, 46,  0,
    47,  0, 48, 49, 50,  0, 51, 52
  };

  localparam logic [7:0] REGIMM_CLS [32] = '{
    53, 54, 55, 56,  0,  0,  0,  0,
    57, 58, 59, 60, 61,  0, 62,  0,
    63, 64, 65, 66,  0,  0,  0,  0,
     0,  0,  0,  0,  0,  0,  0,  0
  };

  // MFC, DMFC, CFC, MTC, DMTC, CTC, BC offsets within a coprocessor group
  localparam logic [3:0] COP_RS_OFF [16] = '{
    1, 2, 3, 0, 4, 5, 6, 0,
    7, 0, 0, 0, 0, 0, 0, 0
  };

  localparam logic [5:0] COP1_FN_OFF [64] = '{
     1,  2,  3,  4,  5,  6,  7,  8,
     9, 10, 11, 12, 13, 14, 15, 16,
     0,  0,  0,  0,  0,  0,  0,  0,
     0,  0,  0,  0,  0,  0,  0,  0,
    17, 18,  0,  0, 19, 20,  0,  0,
     0,  0,  0,  0,  0,  0,  0,  0,
    21, 22, 23, 24, 25, 26, 27, 28,
    29, 30, 31, 32, 33, 34, 35, 36
  };

  localparam logic [7:0] PRIMARY_CLS [64] = '{
      0,   0, 129, 130, 131, 132, 133, 134,
    135, 136, 137, 138, 139, 140, 141, 142,
      0,   0,   0,   0, 143, 144, 145, 146,
    147, 148, 149, 150,   0,   0,   0,   0,
    151, 152, 153, 154, 155, 156, 157, 158,
    159, 160, 161, 162, 163, 164, 165, 166,
    167, 168, 169,   0, 170, 171, 172, 173,
    174, 175, 176,   0, 177, 178, 179, 180
  };

endpackage

// File: rtl/mips_instruction_class_decoder.sv
`timescale 1ns / 1ps
// Each beat passes the input register, then the table lookup, then the result register.
// One beat per cycle while the result side is not stalled; the lookup is one table stage between registers.
// Backpressure on the result side holds the result beat; an empty input stage
// still takes one more beat, then s_tready drops until the result side moves.
// Reset (rst, synchronous) empties both stages; no beat is presented after it.
// ----------------------------------------------------------------------------
// mips_instruction_class_decoder
// Streams instruction words in and returns their dense class number.
// ----------------------------------------------------------------------------
module mips_instruction_class_decoder
  import micd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] instr_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] instr_class
  output logic        m_tuser    // [0] is_invalid
);

  logic        in_valid;
  logic [31:0] in_word;
  logic        advance;
  logic [CLASS_W-1:0] dec_class;
  logic        dec_invalid;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  micd_decode u_decode (
    .instr_word  (in_word),
    .instr_class (dec_class),
    .is_invalid  (dec_invalid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_word <= s_tdata;
    end
    if (advance && in_valid) begin
      m_tdata <= dec_class;
      m_tuser <= dec_invalid;
    end
  end

endmodule

// File: rtl/micd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// micd_decode
// Combinational table lookup from an instruction word to its class.
// ----------------------------------------------------------------------------
module micd_decode
  import micd_pkg::*;
(
  input  logic [31:0]        instr_word,
  output logic [CLASS_W-1:0] instr_class,
  output logic               is_invalid
);

  logic [5:0] opc;
  logic       sel;
  logic [5:0] fn;
  logic [4:0] rt;
  logic [3:0] rs4;
  logic [3:0] rs_off;
  logic [5:0] fn_off;
  logic [7:0] cop_base;
  logic [7:0] rs_class;
  logic [7:0] cop0_fn_class;

  assign opc    = instr_word[OPC_LSB +: 6];
  assign sel    = instr_word[SEL_BIT];
  assign fn     = instr_word[5:0];
  assign rt     = instr_word[RT_LSB +: 5];
  assign rs4    = instr_word[RS_LSB +: 4];
  assign rs_off = COP_RS_OFF[rs4];
  assign fn_off = COP1_FN_OFF[fn];

  always_comb begin
    unique case (opc)
      OPC_COP0: cop_base = COP0_RS_BASE;
      OPC_COP1: cop_base = COP1_RS_BASE;
      default:  cop_base = COP2_RS_BASE;
    endcase
  end

  assign rs_class = (rs_off != 4'd0) ? cop_base + {4'd0, rs_off} : CLS_INVALID;

  always_comb begin
    unique case (fn)
      FN_TLBR:  cop0_fn_class = CLS_TLBR;
      FN_TLBWI: cop0_fn_class = CLS_TLBWI;
      FN_TLBWR: cop0_fn_class = CLS_TLBWR;
      FN_TLBP:  cop0_fn_class = CLS_TLBP;
      FN_ERET:  cop0_fn_class = CLS_ERET;
      default:  cop0_fn_class = CLS_INVALID;
    endcase
  end

  always_comb begin
    unique case (opc)
      OPC_SPECIAL: instr_class = SPECIAL_CLS[fn];
      OPC_REGIMM:  instr_class = REGIMM_CLS[rt];
      OPC_COP0:    instr_class = sel ? cop0_fn_class : rs_class;
      OPC_COP1: begin
        if (sel) begin
          instr_class = (fn_off != 6'd0) ? COP1_FN_BASE + {2'd0, fn_off} : CLS_INVALID;
        end else begin
          instr_class = rs_class;
        end
      end
      // bit 25 set means rs 16..31, all undefined
      OPC_COP2:    instr_class = sel ? CLS_INVALID : rs_class;
      default:     instr_class = PRIMARY_CLS[opc];
    endcase
  end

  assign is_invalid = (instr_class == CLS_INVALID);

endmodule

// File: rtl/micd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// micd_checker
// Port-level checks on the result stream of the class decoder.
// ----------------------------------------------------------------------------
module micd_checker
  import micd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);

  // invalid flag agrees with class zero
  a_flag_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == (m_tdata == CLS_INVALID)))
    else $error("is_invalid disagrees with instr_class");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata <= CLS_MAX))
    else $error("instr_class out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat presented after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result beat changed");

endmodule

bind mips_instruction_class_decoder micd_checker u_micd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: bench/mips_instruction_class_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_instruction_class_decoder_tb
// Drives instruction words through the decoder stream and checks every
// result beat against a table-driven class predictor. A short table of
// directed words covers each decode group and its holes, then random words
// follow, mostly aimed at the sub-decoded opcodes, with random idle on both
// sides and a no-idle stretch in the middle.
// ----------------------------------------------------------------------------
module mips_instruction_class_decoder_tb;
  import micd_pkg::*;

  localparam int RANDOM_WORDS = 400;
  localparam int QUIET_LIMIT  = 1000;

  typedef struct packed {
    logic [7:0] cls;
    logic       bad;
  } decode_t;

  typedef struct {
    logic [31:0] word;
    bit          typed;
    logic [7:0]  cls;
  } probe_t;

  // class numbers by funct, by rt and by primary opcode
  localparam logic [7:0] FUNCT_MAP [64] = '{
     1,  0,  2,  3,  4,  0,  5,  6,
     7,  8,  0,  0,  9, 10,  0, 11,
    12, 13, 14, 15, 16,  0, 17, 18,
    19, 20, 21, 22, 23, 24, 25, 26,
    27, 28, 29, 30, 31, 32, 33, 34,
     0,  0, 35, 36, 37, 38, 39, 40,
    41, 42, 43, 44, 45,  0, 46,  0,
    47,  0, 48, 49, 50,  0, 51, 52
  };

  localparam logic [7:0] RT_MAP [32] = '{
    53, 54, 55, 56,  0,  0,  0,  0,
    57, 58, 59, 60, 61,  0, 62,  0,
    63, 64, 65, 66,  0,  0,  0,  0,
     0,  0,  0,  0,  0,  0,  0,  0
  };

  // MFC, DMFC, CFC, MTC, DMTC, CTC, BC slots of a coprocessor group
  localparam logic [7:0] MOVE_OFF [16] = '{
    1, 2, 3, 0, 4, 5, 6, 0,
    7, 0, 0, 0, 0, 0, 0, 0
  };

  localparam logic [7:0] FPU_OFF [64] = '{
     1,  2,  3,  4,  5,  6,  7,  8,
     9, 10, 11, 12, 13, 14, 15, 16,
     0,  0,  0,  0,  0,  0,  0,  0,
     0,  0,  0,  0,  0,  0,  0,  0,
    17, 18,  0,  0, 19, 20,  0,  0,
     0,  0,  0,  0,  0,  0,  0,  0,
    21, 22, 23, 24, 25, 26, 27, 28,
    29, 30, 31, 32, 33, 34, 35, 36
  };

  localparam logic [7:0] OPCODE_MAP [64] = '{
      0,   0, 129, 130, 131, 132, 133, 134,
    135, 136, 137, 138, 139, 140, 141, 142,
      0,   0,   0,   0, 143, 144, 145, 146,
    147, 148, 149, 150,   0,   0,   0,   0,
    151, 152, 153, 154, 155, 156, 157, 158,
    159, 160, 161, 162, 163, 164, 165, 166,
    167, 168, 169,   0, 170, 171, 172, 173,
    174, 175, 176,   0, 177, 178, 179, 180
  };

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;   // [7:0] instr_class
  logic        m_tuser;   // [0] is_invalid

  decode_t pending_classes[$];
  int      bad_beats  = 0;
  int      quiet_cycles = 0;
  bit      idle_on    = 1'b1;

  mips_instruction_class_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] move_class(logic [3:0] rs, logic [7:0] base);
    return (MOVE_OFF[rs] != 0) ? base + MOVE_OFF[rs] : CLS_INVALID;
  endfunction

  function automatic decode_t classify_word(logic [31:0] w);
    logic [5:0] opc;
    logic [5:0] fn;
    logic [4:0] rs5;
    logic [7:0] cls;
    opc = w[31:26];
    fn  = w[5:0];
    rs5 = w[25:21];
    case (opc)
      OPC_SPECIAL: cls = FUNCT_MAP[fn];
      OPC_REGIMM:  cls = RT_MAP[w[20:16]];
      OPC_COP0: begin
        if (!w[25]) begin
          cls = move_class(w[24:21], COP0_RS_BASE);
        end else begin
          case (fn)
            FN_TLBR:  cls = CLS_TLBR;
            FN_TLBWI: cls = CLS_TLBWI;
            FN_TLBWR: cls = CLS_TLBWR;
            FN_TLBP:  cls = CLS_TLBP;
            FN_ERET:  cls = CLS_ERET;
            default:  cls = CLS_INVALID;
          endcase
        end
      end
      OPC_COP1: begin
        if (!w[25]) begin
          cls = move_class(w[24:21], COP1_RS_BASE);
        end else begin
          cls = (FPU_OFF[fn] != 0) ? COP1_FN_BASE + FPU_OFF[fn] : CLS_INVALID;
        end
      end
      // bit 25 is part of the selector here, so rs 16..31 fall off the table
      OPC_COP2: cls = rs5[4] ? CLS_INVALID : move_class(rs5[3:0], COP2_RS_BASE);
      default:  cls = OPCODE_MAP[opc];
    endcase
    return '{cls: cls, bad: (cls == CLS_INVALID)};
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0, 1: w[31:26] = OPC_SPECIAL;
      2:    w[31:26] = OPC_REGIMM;
      3: begin
        w[31:26] = OPC_COP0;
        if (w[25] && $urandom_range(1) == 1) begin
          case ($urandom_range(4))
            0: w[5:0] = FN_TLBR;
            1: w[5:0] = FN_TLBWI;
            2: w[5:0] = FN_TLBWR;
            3: w[5:0] = FN_TLBP;
            default: w[5:0] = FN_ERET;
          endcase
        end
      end
      4: w[31:26] = OPC_COP1;
      5: begin
        w[31:26] = OPC_COP2;
        if ($urandom_range(3) != 0) w[25] = 1'b0;
      end
      6, 7, 8: w[31:26] = 6'($urandom_range(63));
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_word(input logic [31:0] w, input bit typed, input logic [7:0] cls);
    decode_t want;
    while (idle_on && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (typed) want = '{cls: cls, bad: (cls == CLS_INVALID)};
    else want = classify_word(w);
    pending_classes.push_back(want);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_classes.size() != 0);
  endtask

  probe_t probes [26] = '{
    '{32'h0000_0000, 1'b1, 8'd1},
    '{32'hFFFF_FFFF, 1'b1, 8'd180},
    '{32'h0000_0001, 1'b1, CLS_INVALID},
    '{32'h03FF_FFFF, 1'b1, 8'd52},
    '{{OPC_REGIMM, 5'd0, 5'd0, 16'h0000}, 1'b0, 8'd0},
    '{{OPC_REGIMM, 5'd0, 5'd19, 16'h0000}, 1'b0, 8'd0},
    '{{OPC_REGIMM, 5'd0, 5'd31, 16'h0000}, 1'b1, CLS_INVALID},
    '{{OPC_COP0, 5'd0, 21'd0}, 1'b0, 8'd0},
    '{{OPC_COP0, 5'd3, 21'd0}, 1'b1, CLS_INVALID},
    '{{OPC_COP0, 1'b1, 19'd0, FN_TLBR}, 1'b0, 8'd0},
    '{{OPC_COP0, 1'b1, 19'd0, FN_TLBWI}, 1'b0, 8'd0},
    '{{OPC_COP0, 1'b1, 19'd0, FN_TLBWR}, 1'b0, 8'd0},
    '{{OPC_COP0, 1'b1, 19'd0, FN_TLBP}, 1'b0, 8'd0},
    '{{OPC_COP0, 1'b1, 19'd0, FN_ERET}, 1'b0, 8'd0},
    '{{OPC_COP0, 1'b1, 19'd0, 6'h00}, 1'b1, CLS_INVALID},
    '{{OPC_COP1, 5'd8, 21'd0}, 1'b0, 8'd0},
    '{{OPC_COP1, 1'b1, 19'd0, 6'h00}, 1'b0, 8'd0},
    '{{OPC_COP1, 1'b1, 19'd0, 6'h3F}, 1'b0, 8'd0},
    '{{OPC_COP1, 1'b1, 19'd0, 6'h10}, 1'b1, CLS_INVALID},
    '{{OPC_COP2, 5'd0, 21'd0}, 1'b0, 8'd0},
    '{{OPC_COP2, 5'd8, 21'd0}, 1'b0, 8'd0},
    '{{OPC_COP2, 5'd16, 21'd0}, 1'b1, CLS_INVALID},
    '{{OPC_COP2, 5'd31, 21'h1F_FFFF}, 1'b1, CLS_INVALID},
    '{{6'h02, 26'd0}, 1'b0, 8'd0},
    '{{6'h33, 26'h3FF_FFFF}, 1'b1, CLS_INVALID},
    '{{6'h13, 26'd0}, 1'b1, CLS_INVALID}
  };

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probes[i]) send_word(probes[i].word, probes[i].typed, probes[i].cls);
    drain_results();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      idle_on = !(n >= 150 && n < 250);
      if (n == 300) drain_results();
      send_word(random_word(), 1'b0, CLS_INVALID);
    end
    drain_results();
    repeat (4) @(posedge clk);

    if (bad_beats == 0) begin
      $display("** mips_instruction_class_decoder: PASSED **");
    end else begin
      $display("** mips_instruction_class_decoder: FAILED **");
    end
    $finish;
  end

  always @(posedge clk) begin
    m_tready <= idle_on ? ($urandom_range(99) >= 7) : 1'b1;
  end

  always @(posedge clk) begin
    decode_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_classes.size() == 0) begin
        $error("result beat with nothing expected: instr_class %0d", m_tdata);
        bad_beats++;
      end else begin
        want = pending_classes.pop_front();
        if (m_tdata !== want.cls) begin
          $error("instr_class: expected %0d, got %0d", want.cls, m_tdata);
          bad_beats++;
        end
        if (m_tuser !== want.bad) begin
          $error("is_invalid: expected %0b, got %0b", want.bad, m_tuser);
          bad_beats++;
        end
      end
    end
  end

  // stall watchdog: no beat on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** mips_instruction_class_decoder: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: filelist.f
rtl/micd_pkg.sv
rtl/micd_decode.sv
rtl/mips_instruction_class_decoder.sv
rtl/micd_checker.sv
bench/mips_instruction_class_decoder_tb.sv
